>>> design/vfms_pkg.sv
// Shared constants and types for the frame majority smoother.
`default_nettype none

package vfms_pkg;

   // Field widths of the streams and the register port.
   localparam int SCORE_W    = 16;
   localparam int FRAME_W    = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int HALF_W     = 4;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   // Register indexes of the write port.
   localparam csr_addr_type CSR_WINDOW_HALF       = 2'd0;
   localparam csr_addr_type CSR_THRESHOLD_MODE    = 2'd1;
   localparam csr_addr_type CSR_SILENCE_THRESHOLD = 2'd2;

   // Request kinds carried on req_tuser.
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

endpackage

`default_nettype wire

>>> design/vad_frame_majority_smoother_unit.sv
// Top level of the voice activity majority-vote smoother.
// A frame is accepted in the idle state, which registers its scores; the vote state adds
// its vote and, once the next unlabelled frame has its full window, registers that
// frame's label on rsp_, or waits in the label state while the result side is busy. A new
// frame is taken only in idle; a flush labels the rest one per cycle while rsp_ is free.
// Reset: synchronous, active high; clears the vote window, counts, frame numbering and the
// configuration registers (half width 0, mode 0, threshold 0).
`default_nettype none

module vad_frame_majority_smoother_unit #(
   parameter int MAX_HALF = 15
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata from bit 0 up: silence_score[15:0], speech_score[15:0].
   input  wire logic [2*vfms_pkg::SCORE_W-1:0]      req_tdata,
   // tuser: opcode (0 frame scores, 1 end of stream flush).
   input  wire logic                                req_tuser,
   // Result stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata from bit 0 up: frame_number[15:0], is_silence, seven zero bits.
   output logic [23:0]                              rsp_tdata,
   output logic                                     rsp_tlast,
   // Register write port.
   input  wire logic                                csr_we,
   input  wire vfms_pkg::csr_addr_type              csr_addr,
   input  wire logic [vfms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // The window holds up to 2*MAX_HALF+1 votes, oldest in bit 0.
   localparam int DEPTH = 2 * MAX_HALF + 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VOTE,
      ST_LABEL,
      ST_FLUSH
   } state_type;

   state_type                       state_ff, state_in;
   logic [DEPTH-1:0]                win_ff, win_in;
   logic [CW-1:0]                   held_ff, held_in;
   logic [CW-1:0]                   lab_ff, lab_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [vfms_pkg::FRAME_W-1:0]    oldest_ff, oldest_in;
   logic [vfms_pkg::SCORE_W-1:0]    sil_ff, sil_in;
   logic [vfms_pkg::SCORE_W-1:0]    sp_ff, sp_in;
   logic [vfms_pkg::HALF_W-1:0]     half_ff, half_in;
   logic                            mode_ff, mode_in;
   logic [vfms_pkg::SCORE_W-1:0]    thr_ff, thr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [vfms_pkg::FRAME_W-1:0]    rsp_num_ff, rsp_num_in;
   logic                            rsp_sil_ff, rsp_sil_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [CW-1:0]                   weff;
   logic [CW-1:0]                   win_len;
   logic                            vote;
   logic                            out_free;
   // Window view that the label step works on: the stored window, or in the vote
   // cycle the window with the new vote appended.
   logic [DEPTH-1:0]                cur_win;
   logic [CW-1:0]                   cur_held;
   logic [CW-1:0]                   cur_cnt;
   logic                            need_label;
   // Outcome of one label step.
   logic [DEPTH-1:0]                lab_win;
   logic [CW-1:0]                   lab_held;
   logic [CW-1:0]                   lab_lab;
   logic [CW-1:0]                   lab_cnt;
   logic [vfms_pkg::FRAME_W-1:0]    lab_old;
   logic [vfms_pkg::FRAME_W-1:0]    lab_num;
   logic                            lab_sil;
   logic                            drop;

   // Half widths beyond what the window can hold saturate at MAX_HALF.
   assign weff = (32'(half_ff) > 32'(MAX_HALF)) ? CW'(MAX_HALF) : CW'(half_ff);
   assign win_len = {weff[CW-2:0], 1'b1};

   // A signed comparison, chosen by the mode bit, forms the raw vote.
   assign vote = mode_ff ? ($signed(sil_ff) >= $signed(thr_ff))
                         : ($signed(sil_ff) >= $signed(sp_ff));

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Append the vote in the vote cycle while the window is still filling; in steady
   // state the previous label step has already dropped the oldest vote.
   always_comb begin
      cur_win  = win_ff;
      cur_held = held_ff;
      cur_cnt  = cnt_ff;
      if (state_ff == ST_VOTE && held_ff < win_len) begin
         cur_win[held_ff[IW-1:0]] = vote;
         cur_held = held_ff + CW'(1);
         cur_cnt  = cnt_ff + CW'(vote);
      end
   end

   assign need_label = (cur_held - lab_ff) > weff;

   // Label step: the next unlabelled frame is judged by the votes held, which are
   // exactly the frames of its window seen so far. 2*count > 2W+1 is count > W.
   // Once W older frames sit before it, the oldest vote leaves the window.
   always_comb begin
      lab_num  = oldest_ff + vfms_pkg::FRAME_W'(lab_ff);
      lab_sil  = cur_cnt > weff;
      drop     = (lab_ff >= weff) && (cur_held != '0);
      lab_win  = cur_win;
      lab_held = cur_held;
      lab_lab  = lab_ff + CW'(1);
      lab_cnt  = cur_cnt;
      lab_old  = oldest_ff;
      if (drop) begin
         lab_win  = cur_win >> 1;
         lab_held = cur_held - CW'(1);
         lab_lab  = lab_ff;
         lab_cnt  = cur_cnt - CW'(cur_win[0]);
         lab_old  = oldest_ff + vfms_pkg::FRAME_W'(1);
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      held_in      = held_ff;
      lab_in       = lab_ff;
      cnt_in       = cnt_ff;
      oldest_in    = oldest_ff;
      sil_in       = sil_ff;
      sp_in        = sp_ff;
      half_in      = half_ff;
      mode_in      = mode_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_sil_in   = rsp_sil_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sil_in   = req_tdata[vfms_pkg::SCORE_W-1:0];
               sp_in    = req_tdata[2*vfms_pkg::SCORE_W-1:vfms_pkg::SCORE_W];
               state_in = (req_tuser == vfms_pkg::OP_FLUSH) ? ST_FLUSH : ST_VOTE;
            end
         end
         ST_VOTE: begin
            win_in  = cur_win;
            held_in = cur_held;
            cnt_in  = cur_cnt;
            if (!need_label) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               win_in       = lab_win;
               held_in      = lab_held;
               lab_in       = lab_lab;
               cnt_in       = lab_cnt;
               oldest_in    = lab_old;
               rsp_valid_in = 1'b1;
               rsp_num_in   = lab_num;
               rsp_sil_in   = lab_sil;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_LABEL;
            end
         end
         ST_LABEL: begin
            // The vote is already in the window; wait for the result register.
            if (out_free) begin
               win_in       = lab_win;
               held_in      = lab_held;
               lab_in       = lab_lab;
               cnt_in       = lab_cnt;
               oldest_in    = lab_old;
               rsp_valid_in = 1'b1;
               rsp_num_in   = lab_num;
               rsp_sil_in   = lab_sil;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (lab_ff < held_ff) begin
               if (out_free) begin
                  win_in       = lab_win;
                  held_in      = lab_held;
                  lab_in       = lab_lab;
                  cnt_in       = lab_cnt;
                  oldest_in    = lab_old;
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = lab_num;
                  rsp_sil_in   = lab_sil;
                  rsp_last_in  = !(lab_lab < lab_held);
               end
            end else begin
               // Everything is labelled: empty the window and restart numbering.
               win_in    = '0;
               held_in   = '0;
               lab_in    = '0;
               cnt_in    = '0;
               oldest_in = '0;
               state_in  = ST_IDLE;
            end
         end
      endcase

      // Register writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_we) begin
         unique case (csr_addr)
            vfms_pkg::CSR_WINDOW_HALF: begin
               half_in   = csr_wdata[vfms_pkg::HALF_W-1:0];
               win_in    = '0;
               held_in   = '0;
               lab_in    = '0;
               cnt_in    = '0;
               oldest_in = '0;
            end
            vfms_pkg::CSR_THRESHOLD_MODE: begin
               mode_in = csr_wdata[0];
            end
            vfms_pkg::CSR_SILENCE_THRESHOLD: begin
               thr_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '0;
         held_ff      <= '0;
         lab_ff       <= '0;
         cnt_ff       <= '0;
         oldest_ff    <= '0;
         half_ff      <= '0;
         mode_ff      <= 1'b0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         held_ff      <= held_in;
         lab_ff       <= lab_in;
         cnt_ff       <= cnt_in;
         oldest_ff    <= oldest_in;
         half_ff      <= half_in;
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sil_ff      <= sil_in;
      sp_ff       <= sp_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_sil_ff  <= rsp_sil_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_sil_ff, rsp_num_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
